// ----- rtl/ismc_pkg.sv -----
// Package: shared types and codes of the interrupt status/mask controller.
package ismc_pkg;

  localparam int NUM_SOURCES_DEF = 11;

  localparam int DATA_W   = 32;
  localparam int OFFSET_W = 4;
  localparam int SOURCE_W = 4;
  localparam int FUNC_W   = 2;

  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PULSE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_LINE  = 2'd3;

  localparam logic [1:0] WSEL_STATUS = 2'd0;
  localparam logic [1:0] WSEL_MASK   = 2'd1;

  localparam logic [1:0] LANE_WORD  = 2'd0;
  localparam logic [1:0] LANE_BYTE1 = 2'd1;
  localparam logic [1:0] LANE_HALF  = 2'd2;
  localparam logic [1:0] LANE_BYTE3 = 2'd3;

  localparam logic [DATA_W-1:0] BYTE_MASK = 32'h0000_00FF;
  localparam logic [DATA_W-1:0] HALF_MASK = 32'h0000_FFFF;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   write_data;
    logic [SOURCE_W-1:0] source;
    logic                line_active;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              unhandled;
  } rsp_t;

endpackage

// ----- rtl/interrupt_status_mask_controller_top.sv -----
// Top level of the interrupt status/mask controller.
// Usage:
//   Slave side carries one command per transaction: tuser is the function
//   (read, write, request pulse, line level update); tdata holds offset,
//   write data, source number and line level.
//   Master side returns exactly one result per command: tdata is the read
//   data (zero for anything but a read), tuser flags a read or write of a word
//   other than status (offset 0) or mask (offset 4).
//   m_tvalid rises once the slave transaction has passed through one input
//   register, then the status/mask update and lane extraction, then the
//   result register.
//   One command is taken every cycle while the result register drains; the
//   state registers update as a command passes into the result register, so
//   commands act strictly in order.
//   Reset clears status, mask, line levels and both valid flags.
//   When the master side stalls, the result is held, one more command may
//   enter the input register, and s_tready then drops until the result
//   register can move.
module interrupt_status_mask_controller_top #(
  parameter int NUM_SOURCES = ismc_pkg::NUM_SOURCES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // offset[3:0], write_data[35:4], source[39:36],
                                 // line_active[40], zero fill
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // read_data[31:0]
  output logic [0:0]  m_tuser    // unhandled[0]
);

  ismc_pkg::req_t s_req;
  ismc_pkg::req_t req;
  ismc_pkg::rsp_t rsp;
  ismc_pkg::rsp_t m_rsp;
  logic           stage_valid;
  logic           advance;

  assign s_req.func        = s_tuser;
  assign s_req.offset      = s_tdata[3:0];
  assign s_req.write_data  = s_tdata[35:4];
  assign s_req.source      = s_tdata[39:36];
  assign s_req.line_active = s_tdata[40];

  ismc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_req    (s_req),
    .advance  (advance),
    .valid    (stage_valid),
    .req      (req)
  );

  ismc_core #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (stage_valid && advance),
    .req  (req),
    .rsp  (rsp)
  );

  ismc_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid),
    .rsp      (rsp),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_rsp    (m_rsp)
  );

  assign m_tdata = m_rsp.read_data;
  assign m_tuser = m_rsp.unhandled;

endmodule

// ----- rtl/ismc_in_reg.sv -----
// Input register stage: captures one slave-side transaction.
module ismc_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  ismc_pkg::req_t s_req,
  input  logic          advance,
  output logic          valid,
  output ismc_pkg::req_t req
);

  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req <= s_req;
    end
  end

endmodule

// ----- rtl/ismc_core.sv -----
// Core: status, mask and line level registers and the per-transaction logic.
module ismc_core #(
  parameter int NUM_SOURCES = ismc_pkg::NUM_SOURCES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  ismc_pkg::req_t req,
  output ismc_pkg::rsp_t rsp
);

  logic [NUM_SOURCES-1:0] status;
  logic [NUM_SOURCES-1:0] mask;
  logic [NUM_SOURCES-1:0] line;
  logic [NUM_SOURCES-1:0] status_next;
  logic [NUM_SOURCES-1:0] mask_next;
  logic [NUM_SOURCES-1:0] line_next;

  logic [1:0]                  word_sel;
  logic [1:0]                  lane;
  logic [4:0]                  shift;
  logic                        known;
  logic [ismc_pkg::DATA_W-1:0] cur;
  logic [ismc_pkg::DATA_W-1:0] lane_mask;
  logic [ismc_pkg::DATA_W-1:0] merged;
  logic [ismc_pkg::DATA_W-1:0] rdata;
  logic                        src_ok;
  logic [NUM_SOURCES-1:0]      src_bit;

  assign word_sel = req.offset[3:2];
  assign lane     = req.offset[1:0];
  assign shift    = {lane, 3'b000};
  assign src_ok   = {2'b00, req.source} < 6'(NUM_SOURCES);
  assign src_bit  = NUM_SOURCES'(1) << req.source;

  always_comb begin
    known = 1'b1;
    cur   = '0;
    unique case (word_sel)
      ismc_pkg::WSEL_STATUS: cur = ismc_pkg::DATA_W'(status);
      ismc_pkg::WSEL_MASK:   cur = ismc_pkg::DATA_W'(mask);
      default:               known = 1'b0;
    endcase
  end

  always_comb begin
    unique case (lane)
      ismc_pkg::LANE_WORD: begin
        lane_mask = '1;
        rdata     = cur;
      end
      ismc_pkg::LANE_HALF: begin
        lane_mask = ismc_pkg::HALF_MASK << shift;
        rdata     = (cur >> shift) & ismc_pkg::HALF_MASK;
      end
      default: begin
        lane_mask = ismc_pkg::BYTE_MASK << shift;
        rdata     = (cur >> shift) & ismc_pkg::BYTE_MASK;
      end
    endcase
    merged = (cur & ~lane_mask) | ((req.write_data << shift) & lane_mask);
  end

  always_comb begin
    status_next   = status;
    mask_next     = mask;
    line_next     = line;
    rsp.read_data = '0;
    rsp.unhandled = 1'b0;
    unique case (req.func)
      ismc_pkg::FUNC_READ: begin
        rsp.read_data = rdata;
        rsp.unhandled = !known;
      end
      ismc_pkg::FUNC_WRITE: begin
        rsp.unhandled = !known;
        if (word_sel == ismc_pkg::WSEL_STATUS) begin
          status_next = status & merged[NUM_SOURCES-1:0];
        end else if (word_sel == ismc_pkg::WSEL_MASK) begin
          mask_next = merged[NUM_SOURCES-1:0];
        end
      end
      ismc_pkg::FUNC_PULSE: begin
        if (src_ok) begin
          status_next = status | src_bit;
        end
      end
      default: begin
        if (src_ok) begin
          if (req.line_active) begin
            line_next = line | src_bit;
            if ((line & src_bit) == '0) begin
              status_next = status | src_bit;
            end
          end else begin
            line_next = line & ~src_bit;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      mask   <= '0;
      line   <= '0;
    end else if (fire) begin
      status <= status_next;
      mask   <= mask_next;
      line   <= line_next;
    end
  end

endmodule

// ----- rtl/ismc_out_reg.sv -----
// Output register stage: holds one result for the master side.
module ismc_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  ismc_pkg::rsp_t rsp,
  output logic           advance,
  output logic           m_tvalid,
  input  logic           m_tready,
  output ismc_pkg::rsp_t m_rsp
);

  assign advance = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_rsp <= rsp;
    end
  end

endmodule

// ----- rtl/ismc_checker.sv -----
// Checker: port-level assertions for the controller top level, and its bind.
module ismc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result transaction dropped while stalled");

  a_unhandled_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 32'h0)
    else $error("unhandled access returned data");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with room in the pipeline");

endmodule

bind interrupt_status_mask_controller_top ismc_checker u_ismc_checker (.*);
